// ===== design/assert_macros.svh =====
// Assertion helpers used by calendar_match_search.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock out of reset.
`define CHK_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("check failed");

// Same-cycle implication.
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== design/cms_pkg.sv =====
package cms_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_LOCAL,
    ST_DIV2,
    ST_SPLIT,
    ST_YEAR,
    ST_MONTH,
    ST_SEARCH
  } state_t;

  typedef enum logic [2:0] {
    REG_MONTH  = 3'd0,
    REG_MDAY   = 3'd1,
    REG_WDAY   = 3'd2,
    REG_HOUR   = 3'd3,
    REG_MINUTE = 3'd4,
    REG_OFFSET = 3'd5
  } reg_idx_t;

  localparam int TIME_W = 34;
  localparam int LM_W   = 31;  // local minute count, two's complement
  localparam int DREM_W = 18;
  localparam int CFG_W  = 11;

  localparam logic [11:0] MIN_PER_DAY = 12'd1440;
  localparam logic [LM_W-1:0] MAX_MIN = LM_W'(((64'd1 << TIME_W) - 64'd1) / 64'd60);

  // t / 60 = ((t >> 2) * RECIP15) >> 35, exact for 32-bit operands
  localparam logic [31:0] RECIP15 = 32'd2290649225;
  // v / 1440 = ((v >> 5) * RECIP45) >> 29, exact for 24-bit operands
  localparam logic [31:0] RECIP45 = 32'd11930465;

  localparam logic [3:0] ANY_MONTH  = 4'd0;
  localparam logic [4:0] ANY_MDAY   = 5'd0;
  localparam logic [2:0] ANY_WDAY   = 3'd7;
  localparam logic [4:0] ANY_HOUR   = 5'd24;
  localparam logic [5:0] ANY_MINUTE = 6'd60;

  localparam logic [4:0] LAST_HOUR = 5'd23;
  localparam logic [5:0] LAST_MIN  = 6'd59;

  // 1969-01-01 was a Wednesday
  localparam logic [2:0] WDAY_1969  = 3'd3;
  localparam logic [1:0] Y4_1969    = 2'd1;
  localparam logic [6:0] Y100_1969  = 7'd69;
  localparam logic [8:0] Y400_1969  = 9'd369;

  function automatic logic [4:0] days_in_month(input logic [3:0] mo, input logic leap);
    logic [4:0] n;
    if (mo inside {4'd4, 4'd6, 4'd9, 4'd11}) n = 5'd30;
    else if (mo == 4'd2) n = leap ? 5'd29 : 5'd28;
    else n = 5'd31;
    return n;
  endfunction

  // x mod 7 for x < 56, via reciprocal 37/256
  function automatic logic [2:0] mod7(input logic [5:0] x);
    logic [11:0] p;
    logic [2:0]  q;
    logic [5:0]  r;
    p = 12'(x) * 12'd37;
    q = p[10:8];
    r = x - 6'(q) * 6'd7;
    return r[2:0];
  endfunction

  // x / 60 for x < 1440, via reciprocal 4370/2^18
  function automatic logic [4:0] div60(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd4370;
    return p[22:18];
  endfunction

endpackage

// ===== design/calendar_match_search.sv =====
// Calendar match search. Pulse start while busy is low with opcode and
// reference_time; busy stays high until the single result word appears on
// match_time/found with done high for exactly one cycle. The result cannot be
// stalled: capture it on done. After the accepting edge the block divides the
// time to days, walks each year since 1969 (up to about 545) and each month
// before the start month (up to 11), then makes up to MAX_STEPS search steps.
// The division is two reciprocal multiplies on one shared multiplier; the
// search steps a calendar counter set (minute, hour, day, month, year residues)
// by one field per cycle. Write config only while the block is idle.
`include "assert_macros.svh"

module calendar_match_search #(
  parameter int MAX_STEPS = 200000
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        opcode,
  input  logic [cms_pkg::TIME_W-1:0]  reference_time,
  output logic                        done,
  output logic [cms_pkg::TIME_W-1:0]  match_time,
  output logic                        found,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [cms_pkg::CFG_W-1:0]   cfg_data
);
  import cms_pkg::*;

  localparam int SW = $clog2(MAX_STEPS + 1);

  state_t state, state_next;

  logic [3:0]  want_month;
  logic [4:0]  want_day_of_month;
  logic [2:0]  want_weekday;
  logic [4:0]  want_hour;
  logic [5:0]  want_minute;
  logic [10:0] zone_offset_minutes;

  logic              bwd;
  logic [TIME_W-1:0] dvd;
  logic [10:0]       rem;
  logic              phase;
  logic [63:0]       prod;
  logic [LM_W-1:0]   lmin, dstart;
  logic [DREM_W-1:0] drem;
  logic [SW-1:0]     steps;
  logic [3:0]        mo;
  logic [4:0]        d;
  logic [2:0]        wd;
  logic [4:0]        hh;
  logic [5:0]        mm;
  logic [1:0]        y4;
  logic [6:0]        y100;
  logic [8:0]        y400;

  // shared multiplier: seconds to minutes, then minutes to days
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    mul_a = (state == ST_DIV1) ? dvd[TIME_W-1:2] : 32'(dvd[28:5]);
    mul_b = (state == ST_DIV1) ? RECIP15 : RECIP45;
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  logic [18:0] dq;
  logic [10:0] drm;
  assign dq  = prod[47:29];
  assign drm = dvd[10:0] - 11'(dq[10:0] * MIN_PER_DAY[10:0]);

  logic [LM_W-1:0] off_ext, lmin_init, u;
  assign off_ext   = LM_W'($signed(zone_offset_minutes));
  assign lmin_init = LM_W'(prod[63:35]) + (bwd ? '0 : LM_W'(1)) + off_ext;
  assign u         = lmin - off_ext;

  logic leap;
  logic [4:0] dim_cur, pd;
  logic [3:0] pmo;
  logic [8:0] ylen;
  assign leap    = (y4 == 2'd0) && ((y100 != 7'd0) || (y400 == 9'd0));
  assign dim_cur = days_in_month(mo, leap);
  assign pmo     = (mo == 4'd1) ? 4'd12 : mo - 4'd1;
  assign pd      = days_in_month(pmo, leap);
  assign ylen    = leap ? 9'd366 : 9'd365;

  logic [1:0] y4_inc, y4_dec;
  logic [6:0] y100_inc, y100_dec;
  logic [8:0] y400_inc, y400_dec;
  always_comb begin
    y4_inc   = y4 + 2'd1;
    y4_dec   = y4 - 2'd1;
    y100_inc = (y100 == 7'd99) ? 7'd0 : y100 + 7'd1;
    y100_dec = (y100 == 7'd0) ? 7'd99 : y100 - 7'd1;
    y400_inc = (y400 == 9'd399) ? 9'd0 : y400 + 9'd1;
    y400_dec = (y400 == 9'd0) ? 9'd399 : y400 - 9'd1;
  end

  // field tests
  logic m_ok, dm_ok, h_ok, mn_ok, all_ok, out_range, cap_hit, finish;
  logic year_done, month_done;
  always_comb begin
    m_ok   = (want_month == ANY_MONTH) || (mo == want_month);
    dm_ok  = ((want_day_of_month == ANY_MDAY) || (d == want_day_of_month)) &&
             ((want_weekday == ANY_WDAY) || (wd == want_weekday));
    h_ok   = (want_hour == ANY_HOUR) || (hh == want_hour);
    mn_ok  = (want_minute == ANY_MINUTE) || (mm == want_minute);
    all_ok = m_ok && dm_ok && h_ok && mn_ok;
    out_range  = u[LM_W-1] || (u > MAX_MIN);
    cap_hit    = (steps == SW'(MAX_STEPS));
    finish     = cap_hit || out_range || all_ok;
    year_done  = (drem < DREM_W'(ylen));
    month_done = (drem < DREM_W'(dim_cur));
  end

  // one search move: pick the field level, carries folded in
  logic go_month, go_day, go_hour, go_min;
  logic hh_edge, mm_edge;
  always_comb begin
    hh_edge  = bwd ? (hh == 5'd0) : (hh == LAST_HOUR);
    mm_edge  = bwd ? (mm == 6'd0) : (mm == LAST_MIN);
    go_month = !m_ok;
    go_day   = m_ok && (!dm_ok || (!h_ok && hh_edge) || (!mn_ok && mm_edge && hh_edge));
    go_hour  = m_ok && dm_ok && !go_day && (!h_ok || (!mn_ok && mm_edge));
    go_min   = m_ok && dm_ok && h_ok && !mn_ok && !mm_edge;
  end

  logic [LM_W-1:0] s_lmin, s_dstart;
  logic [3:0] s_mo;
  logic [4:0] s_d, s_hh;
  logic [5:0] s_mm, span;
  logic [2:0] s_wd;
  logic [1:0] s_y4;
  logic [6:0] s_y100;
  logic [8:0] s_y400;
  always_comb begin
    s_lmin = lmin; s_dstart = dstart; s_mo = mo; s_d = d; s_hh = hh; s_mm = mm;
    s_wd = wd; s_y4 = y4; s_y100 = y100; s_y400 = y400;
    span = 6'(dim_cur) - 6'(d) + 6'd1;
    if (go_month || go_day) begin
      if (!bwd) begin
        s_hh = 5'd0; s_mm = 6'd0;
        if (go_month || d == dim_cur) begin
          s_d = 5'd1;
          if (mo == 4'd12) begin
            s_mo = 4'd1; s_y4 = y4_inc; s_y100 = y100_inc; s_y400 = y400_inc;
          end else begin
            s_mo = mo + 4'd1;
          end
        end else begin
          s_d = d + 5'd1;
        end
        if (go_month) begin
          s_dstart = dstart + LM_W'(span) * LM_W'(MIN_PER_DAY);
          s_wd     = mod7(6'(wd) + span);
        end else begin
          s_dstart = dstart + LM_W'(MIN_PER_DAY);
          s_wd     = (wd == 3'd6) ? 3'd0 : wd + 3'd1;
        end
        s_lmin = s_dstart;
      end else begin
        s_hh = LAST_HOUR; s_mm = LAST_MIN;
        if (go_month || d == 5'd1) begin
          s_d  = pd;
          s_mo = pmo;
          if (mo == 4'd1) begin
            s_y4 = y4_dec; s_y100 = y100_dec; s_y400 = y400_dec;
          end
        end else begin
          s_d = d - 5'd1;
        end
        if (go_month) begin
          s_dstart = dstart - LM_W'(d) * LM_W'(MIN_PER_DAY);
          s_wd     = mod7(6'd35 + 6'(wd) - 6'(d));
        end else begin
          s_dstart = dstart - LM_W'(MIN_PER_DAY);
          s_wd     = (wd == 3'd0) ? 3'd6 : wd - 3'd1;
        end
        s_lmin = s_dstart + LM_W'(MIN_PER_DAY) - LM_W'(1);
      end
    end else if (go_hour) begin
      if (!bwd) begin
        s_hh = hh + 5'd1; s_mm = 6'd0;
        s_lmin = lmin + LM_W'(60) - LM_W'(mm);
      end else begin
        s_hh = hh - 5'd1; s_mm = LAST_MIN;
        s_lmin = lmin - LM_W'(mm) - LM_W'(1);
      end
    end else if (go_min) begin
      s_mm   = bwd ? mm - 6'd1 : mm + 6'd1;
      s_lmin = bwd ? lmin - LM_W'(1) : lmin + LM_W'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_DIV1;
      ST_DIV1:   state_next = ST_LOCAL;
      ST_LOCAL:  state_next = ST_DIV2;
      ST_DIV2:   if (phase) state_next = ST_SPLIT;
      ST_SPLIT:  state_next = ST_YEAR;
      ST_YEAR:   if (year_done) state_next = ST_MONTH;
      ST_MONTH:  if (month_done) state_next = ST_SEARCH;
      ST_SEARCH: if (finish) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      want_month          <= ANY_MONTH;
      want_day_of_month   <= ANY_MDAY;
      want_weekday        <= ANY_WDAY;
      want_hour           <= ANY_HOUR;
      want_minute         <= ANY_MINUTE;
      zone_offset_minutes <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MONTH:  want_month          <= cfg_data[3:0];
        REG_MDAY:   want_day_of_month   <= cfg_data[4:0];
        REG_WDAY:   want_weekday        <= cfg_data[2:0];
        REG_HOUR:   want_hour           <= cfg_data[4:0];
        REG_MINUTE: want_minute         <= cfg_data[5:0];
        REG_OFFSET: zone_offset_minutes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == ST_SEARCH && finish) begin
        done  <= 1'b1;
        found <= all_ok && !cap_hit && !out_range;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          bwd <= opcode;
          dvd <= reference_time;
        end
      end
      ST_DIV1: begin
        prod <= mul_p;
      end
      ST_LOCAL: begin
        lmin  <= lmin_init;
        dvd   <= TIME_W'(lmin_init + LM_W'(MIN_PER_DAY));
        phase <= 1'b0;
      end
      ST_DIV2: begin
        if (!phase) begin
          prod  <= mul_p;
          phase <= 1'b1;
        end else begin
          rem <= drm;
          dvd <= TIME_W'(dq);
        end
      end
      ST_SPLIT: begin
        // dvd is days + 1, rem is minute of day
        hh     <= div60(rem);
        mm     <= 6'(rem - 11'(div60(rem)) * 11'd60);
        dstart <= lmin - LM_W'(rem);
        drem   <= dvd[DREM_W-1:0] + DREM_W'(364);
        wd     <= WDAY_1969;
        y4     <= Y4_1969;
        y100   <= Y100_1969;
        y400   <= Y400_1969;
      end
      ST_YEAR: begin
        if (year_done) begin
          mo <= 4'd1;
        end else begin
          drem <= drem - DREM_W'(ylen);
          wd   <= mod7(6'(wd) + (leap ? 6'd2 : 6'd1));
          y4   <= y4_inc;
          y100 <= y100_inc;
          y400 <= y400_inc;
        end
      end
      ST_MONTH: begin
        if (month_done) begin
          d     <= drem[4:0] + 5'd1;
          wd    <= mod7(6'(wd) + 6'(drem[4:0]));
          steps <= '0;
        end else begin
          drem <= drem - DREM_W'(dim_cur);
          mo   <= mo + 4'd1;
          wd   <= mod7(6'(wd) + 6'(dim_cur) - 6'd28);
        end
      end
      ST_SEARCH: begin
        if (finish) begin
          // u * 60 as (u << 6) - (u << 2)
          match_time <= (all_ok && !cap_hit && !out_range) ?
                        ((TIME_W'(u[28:0]) << 6) - (TIME_W'(u[28:0]) << 2)) : '0;
        end else begin
          steps  <= steps + SW'(1);
          lmin   <= s_lmin;
          dstart <= s_dstart;
          mo     <= s_mo;
          d      <= s_d;
          hh     <= s_hh;
          mm     <= s_mm;
          wd     <= s_wd;
          y4     <= s_y4;
          y100   <= s_y100;
          y400   <= s_y400;
        end
      end
      default: ;
    endcase
  end

  `CHK_IMPL(a_done_idle, done, !busy)
  `CHK_IMPL(a_miss_zero, done && !found, match_time == '0)
  `CHK_IMPL(a_cal_valid, state == ST_SEARCH, mo >= 4'd1 && mo <= 4'd12 && d >= 5'd1 && d <= dim_cur)
  `CHK_NEXT(a_start_busy, start && !busy, busy)

endmodule
